[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the speed meter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag an expression that must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("invariant violated");

// Flag a consequent that does not hold in the cycle of its antecedent.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

[rtl/core/lgsm_pkg.sv]
// ---------------------------------------------------------------------------
// lgsm_pkg
// Types, constants and step table shared by the speed meter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package lgsm_pkg;

  localparam int unsigned TICK_WIDTH_DEF = 32;

  // Item selector codes
  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_BUTTON = 2'd2
  } func_e;

  // Configuration
  localparam int unsigned DIST_W       = 8;
  localparam int unsigned THR_W        = 9;
  localparam int unsigned THR_RESET    = 300;
  localparam int unsigned ADDR_W       = 3;
  localparam int unsigned DATA_W       = 32;
  localparam logic        REG_DISTANCE = 1'b0;
  localparam logic        REG_THRESH   = 1'b1;

  // Sample scaling: centivolts = sample * 500 / 1023
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned ADC_SCALE = 500;
  localparam int unsigned ADC_FULL  = 1023;
  localparam int unsigned CV_W      = 20;

  // Speed: distance * 1250 * 125 / (22 * ticks)
  localparam int unsigned INCH_PER_LSB = 1250;
  localparam int unsigned CENTI_SCALE  = 125;
  localparam int unsigned DIST_SCALE   = INCH_PER_LSB * CENTI_SCALE;
  localparam int unsigned DIVIDEND_W   = 26;
  localparam int unsigned SPEED_W      = 21;
  localparam int unsigned HEAD_W       = DIVIDEND_W - SPEED_W;

  // Decimal conversion
  localparam int unsigned DIGITS        = 5;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned DIGITS_W      = DIGITS * DIGIT_W;
  localparam int unsigned MOD_STEPS     = 5;
  localparam int unsigned DEC_STEPS     = MOD_STEPS + DIGITS_W;
  localparam int unsigned CNT_W         = $clog2(DEC_STEPS);
  localparam int unsigned DISPLAY_LIMIT = 100000;
  localparam int unsigned OUT_TICK_W    = 32;

  // Constants subtracted in turn: first reduce modulo 100000, then strip
  // each decimal digit as weights 8, 4, 2, 1 of its power of ten.
  localparam logic [SPEED_W-1:0] DEC_STEP [DEC_STEPS] = '{
    21'd1600000, 21'd800000, 21'd400000, 21'd200000, 21'd100000,
    21'd80000,   21'd40000,  21'd20000,  21'd10000,
    21'd8000,    21'd4000,   21'd2000,   21'd1000,
    21'd800,     21'd400,    21'd200,    21'd100,
    21'd80,      21'd40,     21'd20,     21'd10,
    21'd8,       21'd4,      21'd2,      21'd1
  };

  typedef struct packed {
    logic first;
    logic second;
  } gate_t;

  typedef struct packed {
    logic busy;
    logic done;
  } calc_stat_t;

  typedef struct packed {
    logic [SPEED_W-1:0]  speed;
    logic [DIGITS_W-1:0] digits;
    logic                overflow;
    logic                zero_time;
  } calc_res_t;

endpackage

`default_nettype wire

[rtl/core/lgsm_sub_unit.sv]
// ---------------------------------------------------------------------------
// lgsm_sub_unit
// Shared compare-and-subtract unit for division and decimal steps.
// ---------------------------------------------------------------------------
`default_nettype none

module lgsm_sub_unit #(
  parameter int unsigned WIDTH = 38
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic [WIDTH-1:0] diff_o,
  output logic             ge_o
);

  logic [WIDTH:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[WIDTH-1:0];
  assign ge_o   = ~full[WIDTH];

endmodule

`default_nettype wire

[rtl/core/lgsm_gate_cmp.sv]
// ---------------------------------------------------------------------------
// lgsm_gate_cmp
// Threshold test of both gate samples against the blocking level.
// ---------------------------------------------------------------------------
`default_nettype none

module lgsm_gate_cmp (
  input  logic [lgsm_pkg::SAMPLE_W-1:0] first_i,
  input  logic [lgsm_pkg::SAMPLE_W-1:0] second_i,
  input  logic [lgsm_pkg::THR_W-1:0]    thr_i,
  output lgsm_pkg::gate_t               gate_o
);

  import lgsm_pkg::*;

  logic [CV_W-1:0] first_lvl;
  logic [CV_W-1:0] second_lvl;
  logic [CV_W-1:0] limit;

  // floor(x*500/1023) > thr  <=>  x*500 >= (thr+1)*1023
  assign first_lvl  = CV_W'(first_i) * CV_W'(ADC_SCALE);
  assign second_lvl = CV_W'(second_i) * CV_W'(ADC_SCALE);
  assign limit      = (CV_W'(thr_i) + CV_W'(1)) * CV_W'(ADC_FULL);

  assign gate_o.first  = (first_lvl >= limit);
  assign gate_o.second = (second_lvl >= limit);

endmodule

`default_nettype wire

[rtl/core/lgsm_calc.sv]
// ---------------------------------------------------------------------------
// lgsm_calc
// Sequencer for speed division and decimal conversion on one subtractor.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lgsm_calc #(
  parameter int unsigned TICK_WIDTH = lgsm_pkg::TICK_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lgsm_pkg::DIST_W-1:0] distance_i,
  input  logic [TICK_WIDTH-1:0]       ticks_i,
  input  logic                        ack_i,
  output lgsm_pkg::calc_stat_t        stat_o,
  output lgsm_pkg::calc_res_t         res_o
);

  import lgsm_pkg::*;

  localparam int unsigned DVS_W = TICK_WIDTH + 5;
  localparam int unsigned UNIT_W = DVS_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DEC,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DVS_W-1:0]    rem_q;
  logic [DVS_W-1:0]    dvs_q;
  logic [SPEED_W-1:0]  quo_q;
  logic [SPEED_W-1:0]  spd_q;
  logic [DIGITS_W-1:0] dig_q;
  logic                ovf_q;
  logic                zero_q;

  logic [DIVIDEND_W-1:0] dividend;
  logic [DVS_W-1:0]      dvs_start;
  logic [UNIT_W-1:0]     shifted;
  logic [UNIT_W-1:0]     op_a;
  logic [UNIT_W-1:0]     op_b;
  logic [UNIT_W-1:0]     diff;
  logic                  ge;

  assign dividend  = DIVIDEND_W'(distance_i * DIST_SCALE);
  // 22 * ticks as 16 + 4 + 2
  assign dvs_start = {1'b0, ticks_i, 4'b0} + {3'b0, ticks_i, 2'b0} + {4'b0, ticks_i, 1'b0};
  assign shifted   = {rem_q, quo_q[SPEED_W-1]};

  always_comb begin
    if (state_q == S_DIV) begin
      op_a = shifted;
      op_b = {1'b0, dvs_q};
    end else begin
      op_a = UNIT_W'(quo_q);
      op_b = UNIT_W'(DEC_STEP[cnt_q]);
    end
  end

  lgsm_sub_unit #(
    .WIDTH (UNIT_W)
  ) u_sub (
    .a_i    (op_a),
    .b_i    (op_b),
    .diff_o (diff),
    .ge_o   (ge)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      dvs_q   <= '0;
      quo_q   <= '0;
      spd_q   <= '0;
      dig_q   <= '0;
      ovf_q   <= 1'b0;
      zero_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cnt_q  <= '0;
            dvs_q  <= dvs_start;
            ovf_q  <= 1'b0;
            zero_q <= (ticks_i == '0);
            if (ticks_i == '0) begin
              // no tick counted: speed forced to zero
              quo_q   <= '0;
              spd_q   <= '0;
              state_q <= S_DEC;
            end else begin
              rem_q   <= DVS_W'(dividend[DIVIDEND_W-1:SPEED_W]);
              quo_q   <= dividend[SPEED_W-1:0];
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
          quo_q <= {quo_q[SPEED_W-2:0], ge};
          if (cnt_q == CNT_W'(SPEED_W - 1)) begin
            spd_q   <= {quo_q[SPEED_W-2:0], ge};
            cnt_q   <= '0;
            state_q <= S_DEC;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_DEC: begin
          if (ge) begin
            quo_q <= diff[SPEED_W-1:0];
          end
          if (cnt_q < CNT_W'(MOD_STEPS)) begin
            ovf_q <= ovf_q | ge;
          end else begin
            dig_q <= {dig_q[DIGITS_W-2:0], ge};
          end
          if (cnt_q == CNT_W'(DEC_STEPS - 1)) begin
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_DONE: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign stat_o.busy      = (state_q != S_IDLE);
  assign stat_o.done      = (state_q == S_DONE);
  assign res_o.speed      = spd_q;
  assign res_o.digits     = dig_q;
  assign res_o.overflow   = ovf_q;
  assign res_o.zero_time  = zero_q;

  `ASSERT_IMPLIES(a_rem_below_divisor, clk_i, rst_ni, state_q == S_DIV, rem_q < dvs_q)
  `ASSERT_IMPLIES(a_zero_skips_division, clk_i, rst_ni, state_q == S_DIV, !zero_q)
  `ASSERT_IMPLIES(a_ack_only_when_done, clk_i, rst_ni, ack_i, state_q == S_DONE)

endmodule

`default_nettype wire

[rtl/core/light_gate_speed_meter.sv]
// ---------------------------------------------------------------------------
// light_gate_speed_meter
// Times an object between two light gates and reports its speed.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Carries
//   --------  ---------  -------------------  --------------------------------
//   in        sink       in_valid_i/ready_o   func, both gate samples
//   out       source     out_valid_o/ready_i  speed, ticks, digits, flags
//   apb       slave      psel/penable/pready  gate_distance, block_threshold
//
// Tick, button and non-stopping sample items take effect when accepted.
// A sample item that stops timing hands the tick count to the calculation
// sequencer: 21 division steps and then 25 decimal steps on one shared
// subtractor, then a hand-over of the result to the output register (the
// division steps are skipped when no tick was counted). in_ready_o is low while it runs.
// The result sits in an output register, so items keep flowing while it
// waits to be taken; a finished calculation holds until that register frees.
// Reset is asynchronous, active low, and needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module light_gate_speed_meter #(
  parameter int unsigned TICK_WIDTH = lgsm_pkg::TICK_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lgsm_pkg::ADDR_W-1:0]   paddr,
  input  logic [lgsm_pkg::DATA_W-1:0]   pwdata,
  output logic [lgsm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [lgsm_pkg::SAMPLE_W-1:0] first_gate_sample_i,
  input  logic [lgsm_pkg::SAMPLE_W-1:0] second_gate_sample_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lgsm_pkg::SPEED_W-1:0]  speed_centi_mph_o,
  output logic [31:0]                   elapsed_ticks_o,
  output logic [3:0]                    digit_hundreds_o,
  output logic [3:0]                    digit_tens_o,
  output logic [3:0]                    digit_units_o,
  output logic [3:0]                    digit_tenths_o,
  output logic [3:0]                    digit_hundredths_o,
  output logic                          display_overflow_o,
  output logic                          zero_time_o
);

  import lgsm_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_ARMED,
    PH_REC
  } phase_e;

  phase_e                  phase_q;
  logic [TICK_WIDTH-1:0]   tick_q;
  logic [DIST_W-1:0]       dist_q;
  logic [THR_W-1:0]        thr_q;
  logic                    out_valid_q;
  logic [SPEED_W-1:0]      speed_q;
  logic [OUT_TICK_W-1:0]   ticks_out_q;
  logic [DIGITS_W-1:0]     dig_q;
  logic                    ovf_q;
  logic                    zero_q;

  gate_t                   gate;
  calc_stat_t              calc_stat;
  calc_res_t               calc_res;
  logic                    in_fire;
  logic                    cfg_wr;
  logic                    start_first;
  logic                    stop_now;
  logic                    calc_ack;
  logic [TICK_WIDTH+OUT_TICK_W-1:0] tick_ext;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign in_fire = in_valid_i & in_ready_o;

  // Hold off new items while the sequencer is working on or holding a result.
  assign in_ready_o = ~calc_stat.busy;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_THRESH) begin
      prdata = DATA_W'(thr_q);
    end else begin
      prdata = DATA_W'(dist_q);
    end
  end

  lgsm_gate_cmp u_gate_cmp (
    .first_i  (first_gate_sample_i),
    .second_i (second_gate_sample_i),
    .thr_i    (thr_q),
    .gate_o   (gate)
  );

  // A sample may start and stop timing in the same item.
  assign start_first = (phase_q == PH_ARMED) && gate.first;
  assign stop_now    = in_fire && (func_i == FUNC_SAMPLE) && gate.second &&
                       ((phase_q == PH_REC) || start_first);

  lgsm_calc #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_calc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (stop_now),
    .distance_i (dist_q),
    .ticks_i    (start_first ? '0 : tick_q),
    .ack_i      (calc_ack),
    .stat_o     (calc_stat),
    .res_o      (calc_res)
  );

  // Take the result once the output register is free or being drained.
  assign calc_ack = calc_stat.done & (~out_valid_q | out_ready_i);
  assign tick_ext = {{OUT_TICK_W{1'b0}}, tick_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      tick_q      <= '0;
      dist_q      <= '0;
      thr_q       <= THR_W'(THR_RESET);
      out_valid_q <= 1'b0;
      speed_q     <= '0;
      ticks_out_q <= '0;
      dig_q       <= '0;
      ovf_q       <= 1'b0;
      zero_q      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_THRESH) begin
          thr_q <= pwdata[THR_W-1:0];
        end else begin
          dist_q <= pwdata[DIST_W-1:0];
        end
      end

      if (in_fire) begin
        case (func_i)
          FUNC_TICK: begin
            // advance while recording, saturate at full scale
            if (phase_q == PH_REC && tick_q != '1) begin
              tick_q <= tick_q + TICK_WIDTH'(1);
            end
          end
          FUNC_BUTTON: begin
            if (phase_q == PH_WAIT) begin
              phase_q <= PH_ARMED;
            end
          end
          FUNC_SAMPLE: begin
            if (start_first) begin
              tick_q  <= '0;
              phase_q <= PH_REC;
            end
            if (stop_now) begin
              phase_q <= PH_WAIT;
            end
          end
          default: ;  // drop items with an unused selector
        endcase
      end

      if (calc_ack) begin
        out_valid_q <= 1'b1;
        speed_q     <= calc_res.speed;
        ticks_out_q <= tick_ext[OUT_TICK_W-1:0];
        dig_q       <= calc_res.digits;
        ovf_q       <= calc_res.overflow;
        zero_q      <= calc_res.zero_time;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign speed_centi_mph_o  = speed_q;
  assign elapsed_ticks_o    = ticks_out_q;
  assign digit_hundreds_o   = dig_q[5*DIGIT_W-1:4*DIGIT_W];
  assign digit_tens_o       = dig_q[4*DIGIT_W-1:3*DIGIT_W];
  assign digit_units_o      = dig_q[3*DIGIT_W-1:2*DIGIT_W];
  assign digit_tenths_o     = dig_q[2*DIGIT_W-1:DIGIT_W];
  assign digit_hundredths_o = dig_q[DIGIT_W-1:0];
  assign display_overflow_o = ovf_q;
  assign zero_time_o        = zero_q;

  `ASSERT_NEVER(a_calc_only_when_waiting, clk_i, rst_ni, calc_stat.busy && (phase_q != PH_WAIT))
  `ASSERT_IMPLIES(a_zero_time_speed, clk_i, rst_ni, out_valid_q && zero_q, speed_q == '0)
  `ASSERT_IMPLIES(a_overflow_flag, clk_i, rst_ni, out_valid_q && !ovf_q, speed_q < SPEED_W'(DISPLAY_LIMIT))

endmodule

`default_nettype wire
